### sv/mecanum_wheel_speed_mixer_unit_assert.svh
// Assertion macros for the mecanum wheel speed mixer
`ifndef MECANUM_WHEEL_SPEED_MIXER_UNIT_ASSERT_SVH
`define MECANUM_WHEEL_SPEED_MIXER_UNIT_ASSERT_SVH

// expr must never hold
`define MWSM_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

// same-cycle implication
`define MWSM_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MWSM_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/mwsm_pkg.sv
// Shared constants, types and width helpers for the mecanum wheel speed mixer
`timescale 1ns / 1ps

package mwsm_pkg;

  localparam int unsigned TRIG_FRAC_BITS_DEF = 15;
  localparam int unsigned ANGLE_BITS_DEF     = 16;

  localparam int unsigned CFG_W         = 15;
  localparam logic [CFG_W-1:0] MAX_SPEED_RST = 15'd660;

  localparam int unsigned NWHEEL       = 4;
  localparam int unsigned WW_EXTRA     = 20;
  localparam int unsigned SIN_STAGES   = 5;
  localparam int unsigned FRONT_STAGES = 10;
  localparam int unsigned QDEPTH       = 4;

  // quarter-wave sine polynomial, Q2.30
  localparam logic [30:0] SIN_A = 31'd1686629713;
  localparam logic [29:0] SIN_B = 30'd688904866;
  localparam logic [26:0] SIN_C = 27'd76016977;

  localparam logic [15:0] SAT_MAX = 16'h7fff;
  localparam logic [15:0] SAT_MIN = 16'h8000;

  typedef struct packed {
    logic full;
    logic nempty;
  } q_stat_t;

  function automatic int unsigned wheel_w(int unsigned frac);
    return frac + WW_EXTRA;
  endfunction

  function automatic int unsigned entry_w(int unsigned frac);
    return (NWHEEL + 1) * (wheel_w(frac) + 1);
  endfunction

endpackage

### sv/mwsm_sin.sv
// Pipelined fixed-point sine of a quadrant and in-quadrant position
`timescale 1ns / 1ps

module mwsm_sin #(
  parameter int unsigned TRIG_FRAC_BITS = mwsm_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [1:0]                     quad_i,
  input  logic [15:0]                    x_i,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_o
);

  localparam int unsigned TW = TRIG_FRAC_BITS + 2;

  logic [16:0] xq;
  logic [33:0] sq;
  logic [16:0] s1_x_q, s1_x2_q, s2_x_q, s2_x2_q, s3_x_q;
  logic [43:0] s2_p_q;
  logic [29:0] t1;
  logic [46:0] s3_p_q;
  logic [30:0] t2;
  logic [47:0] s4_p_q;
  logic [3:0]  neg_q;
  logic [32:0] rs, rsh;
  logic [TW-1:0] r, res_q;

  always_comb begin
    xq = quad_i[0] ? (17'h10000 - {1'b0, x_i}) : {1'b0, x_i};
    sq = xq * xq;
    t1 = mwsm_pkg::SIN_B - s2_p_q[43:16];
    t2 = mwsm_pkg::SIN_A - s3_p_q[46:16];
    rs = {1'b0, s4_p_q[47:16]} + (33'd1 << (29 - TRIG_FRAC_BITS));
    rsh = rs >> (30 - TRIG_FRAC_BITS);
    r = rsh[TW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_x_q  <= xq;
      s1_x2_q <= sq[32:16];
      s2_p_q  <= mwsm_pkg::SIN_C * s1_x2_q;
      s2_x_q  <= s1_x_q;
      s2_x2_q <= s1_x2_q;
      s3_p_q  <= t1 * s2_x2_q;
      s3_x_q  <= s2_x_q;
      s4_p_q  <= t2 * s3_x_q;
      neg_q   <= {neg_q[2:0], quad_i[1]};
      res_q   <= neg_q[3] ? (TW'(0) - r) : r;
    end
  end

  assign sin_o = res_q;

endmodule

### sv/mwsm_front.sv
// Front end: accepts commands, rotates into the chassis frame, mixes wheels, finds the peak
`timescale 1ns / 1ps

module mwsm_front #(
  parameter int unsigned TRIG_FRAC_BITS = mwsm_pkg::TRIG_FRAC_BITS_DEF,
  parameter int unsigned ANGLE_BITS     = mwsm_pkg::ANGLE_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [15:0]      vel_x_i,
  input  logic signed [15:0]      vel_y_i,
  input  logic signed [15:0]      turn_rate_i,
  input  logic [15:0]             heading_i,
  input  logic [mwsm_pkg::CFG_W-1:0] max_speed_i,
  input  mwsm_pkg::q_stat_t       q_stat_i,
  output logic                    q_push_o,
  output logic [mwsm_pkg::entry_w(TRIG_FRAC_BITS)-1:0] q_wdata_o
);

  localparam int unsigned TW = TRIG_FRAC_BITS + 2;
  localparam int unsigned PW = 16 + TW;
  localparam int unsigned FW = PW + 1;
  localparam int unsigned WW = mwsm_pkg::wheel_w(TRIG_FRAC_BITS);
  localparam int unsigned EW = mwsm_pkg::entry_w(TRIG_FRAC_BITS);
  localparam int unsigned NS = mwsm_pkg::FRONT_STAGES;
  localparam int unsigned SL = mwsm_pkg::SIN_STAGES;
  localparam int unsigned NW = mwsm_pkg::NWHEEL;

  logic fen;
  logic [NS-1:0] v_q;
  logic [47:0] phase_wide;
  logic [31:0] phase;
  logic signed [TW-1:0] sin_s, cos_s;
  logic signed [15:0] vx_q [SL];
  logic signed [15:0] vy_q [SL];
  logic signed [15:0] om_q [SL];
  logic signed [PW-1:0] p_yc_q, p_xs_q, p_xc_q, p_ys_q;
  logic signed [15:0] om6_q;
  logic signed [FW-1:0] fb_q, lr_q;
  logic signed [WW-1:0] wo_q, fbx, lrx;
  logic signed [WW-1:0] w_s [NW];
  logic [WW-1:0] mag_d [NW];
  logic [WW-1:0] mag8_q [NW];
  logic [WW-1:0] mag9_q [NW];
  logic [WW-1:0] mag10_q [NW];
  logic [NW-1:0] neg8_q, neg9_q, neg10_q;
  logic [WW-1:0] max01_q, max23_q, big_q, limit;
  logic scale;

  assign fen        = !(v_q[NS-1] && q_stat_i.full);
  assign in_stall_o = !fen;
  assign q_push_o   = v_q[NS-1] && fen;

  assign phase_wide = 48'(heading_i) << (32 - ANGLE_BITS);
  assign phase      = phase_wide[31:0];

  mwsm_sin #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_sin (
    .clk_i  (clk_i),
    .en_i   (fen),
    .quad_i (phase[31:30]),
    .x_i    (phase[29:14]),
    .sin_o  (sin_s)
  );

  mwsm_sin #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cos (
    .clk_i  (clk_i),
    .en_i   (fen),
    .quad_i (phase[31:30] + 2'd1),
    .x_i    (phase[29:14]),
    .sin_o  (cos_s)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (fen) begin
      v_q <= {v_q[NS-2:0], in_valid_i};
    end
  end

  always_comb begin
    fbx = WW'(fb_q);
    lrx = WW'(lr_q);
    w_s[0] = lrx - fbx + wo_q;
    w_s[1] = fbx + lrx + wo_q;
    w_s[2] = fbx - lrx + wo_q;
    w_s[3] = wo_q - fbx - lrx;
    for (int k = 0; k < NW; k++) begin
      mag_d[k] = w_s[k][WW-1] ? WW'(-w_s[k]) : WW'(w_s[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fen) begin
      vx_q[0] <= vel_x_i;
      vy_q[0] <= vel_y_i;
      om_q[0] <= turn_rate_i;
      for (int i = 1; i < SL; i++) begin
        vx_q[i] <= vx_q[i-1];
        vy_q[i] <= vy_q[i-1];
        om_q[i] <= om_q[i-1];
      end
      p_yc_q <= vy_q[SL-1] * cos_s;
      p_xs_q <= vx_q[SL-1] * sin_s;
      p_xc_q <= vx_q[SL-1] * cos_s;
      p_ys_q <= vy_q[SL-1] * sin_s;
      om6_q  <= om_q[SL-1];
      fb_q   <= FW'(p_yc_q) + FW'(p_xs_q);
      lr_q   <= FW'(p_xc_q) - FW'(p_ys_q);
      wo_q   <= WW'(om6_q) <<< TRIG_FRAC_BITS;
      for (int k = 0; k < NW; k++) begin
        mag8_q[k]  <= mag_d[k];
        neg8_q[k]  <= w_s[k][WW-1];
        mag9_q[k]  <= mag8_q[k];
        mag10_q[k] <= mag9_q[k];
      end
      neg9_q  <= neg8_q;
      neg10_q <= neg9_q;
      max01_q <= (mag8_q[0] > mag8_q[1]) ? mag8_q[0] : mag8_q[1];
      max23_q <= (mag8_q[2] > mag8_q[3]) ? mag8_q[2] : mag8_q[3];
      big_q   <= (max01_q > max23_q) ? max01_q : max23_q;
    end
  end

  assign limit = WW'(max_speed_i) << TRIG_FRAC_BITS;
  assign scale = big_q > limit;

  always_comb begin
    q_wdata_o[EW-1]            = scale;
    q_wdata_o[NW*(WW+1) +: WW] = big_q;
    for (int k = 0; k < NW; k++) begin
      q_wdata_o[k*(WW+1) +: WW+1] = {neg10_q[k], mag10_q[k]};
    end
  end

endmodule

### sv/mwsm_queue.sv
// Short request queue between the front and back ends
`timescale 1ns / 1ps

module mwsm_queue #(
  parameter int unsigned W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [W-1:0]      wdata_i,
  input  logic              pop_i,
  output logic [W-1:0]      rdata_o,
  output mwsm_pkg::q_stat_t stat_o
);

  localparam int unsigned D  = mwsm_pkg::QDEPTH;
  localparam int unsigned AW = $clog2(D);

  logic [W-1:0]  mem_q [D];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  assign rdata_o       = mem_q[rd_q];
  assign stat_o.full   = (cnt_q == (AW+1)'(D));
  assign stat_o.nempty = (cnt_q != '0);

endmodule

### sv/mwsm_back.sv
// Back end: proportional scaling by a pipelined divider, saturation, output register
`timescale 1ns / 1ps

module mwsm_back #(
  parameter int unsigned TRIG_FRAC_BITS = mwsm_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mwsm_pkg::q_stat_t       q_stat_i,
  input  logic [mwsm_pkg::entry_w(TRIG_FRAC_BITS)-1:0] q_rdata_i,
  output logic                    q_pop_o,
  input  logic [mwsm_pkg::CFG_W-1:0] max_speed_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [15:0]      wheel_front_left_o,
  output logic signed [15:0]      wheel_front_right_o,
  output logic signed [15:0]      wheel_rear_right_o,
  output logic signed [15:0]      wheel_rear_left_o,
  output logic                    was_scaled_o
);

  localparam int unsigned WW   = mwsm_pkg::wheel_w(TRIG_FRAC_BITS);
  localparam int unsigned EW   = mwsm_pkg::entry_w(TRIG_FRAC_BITS);
  localparam int unsigned DB   = mwsm_pkg::CFG_W;
  localparam int unsigned HALF = (WW + 1) / 2;
  localparam int unsigned HW   = WW - HALF;
  localparam int unsigned NB   = WW + DB;
  localparam int unsigned MW   = WW - TRIG_FRAC_BITS;
  localparam int unsigned NV   = DB + 2;
  localparam int unsigned NW   = mwsm_pkg::NWHEEL;

  logic ben;
  logic [NV-1:0] vb_q;
  logic out_valid_q;

  logic [WW-1:0] in_mag [NW];
  logic [NW-1:0] in_neg;
  logic [WW-1:0] in_big;
  logic          in_scale;
  logic [MW-1:0] m [NW];
  logic [15:0]   u_d [NW];

  logic [HALF+DB-1:0] lo1_q [NW];
  logic [HW+DB-1:0]   hi1_q [NW];
  logic [15:0]        u1_q [NW];
  logic [NW-1:0]      neg1_q;
  logic [WW-1:0]      big1_q;
  logic               sc1_q;

  logic [NB-1:0] num_d [NW];
  logic [WW-1:0] rem_d [DB+1][NW];
  logic [WW-1:0] rem_q [DB+1][NW];
  logic [DB-1:0] nq_d  [DB+1][NW];
  logic [DB-1:0] nq_q  [DB+1][NW];
  logic [15:0]   du_q  [DB+1][NW];
  logic [NW-1:0] dneg_q [DB+1];
  logic [WW-1:0] dbig_q [DB+1];
  logic          dsc_q  [DB+1];

  logic [15:0] res_d [NW];
  logic [15:0] wheel_q [NW];
  logic        scaled_q;

  assign ben     = !(out_valid_q && out_stall_i);
  assign q_pop_o = ben && q_stat_i.nempty;

  always_comb begin
    in_scale = q_rdata_i[EW-1];
    in_big   = q_rdata_i[NW*(WW+1) +: WW];
    for (int k = 0; k < NW; k++) begin
      in_mag[k] = q_rdata_i[k*(WW+1) +: WW];
      in_neg[k] = q_rdata_i[k*(WW+1) + WW];
      m[k] = in_mag[k][WW-1:TRIG_FRAC_BITS];
      if (in_neg[k]) begin
        u_d[k] = (m[k] > MW'(mwsm_pkg::SAT_MIN)) ? mwsm_pkg::SAT_MIN : (16'h0 - m[k][15:0]);
      end else begin
        u_d[k] = (m[k] > MW'(mwsm_pkg::SAT_MAX)) ? mwsm_pkg::SAT_MAX : m[k][15:0];
      end
    end
  end

  // restoring division, one quotient bit per stage
  always_comb begin
    logic [WW:0] t;
    logic        ge;
    t  = '0;
    ge = 1'b0;
    for (int k = 0; k < NW; k++) begin
      num_d[k]    = (NB'(hi1_q[k]) << HALF) + NB'(lo1_q[k]);
      rem_d[0][k] = num_d[k][NB-1:DB];
      nq_d[0][k]  = num_d[k][DB-1:0];
    end
    for (int j = 1; j <= DB; j++) begin
      for (int k = 0; k < NW; k++) begin
        t  = {rem_q[j-1][k], nq_q[j-1][k][DB-1]};
        ge = t >= {1'b0, dbig_q[j-1]};
        rem_d[j][k] = ge ? WW'(t - {1'b0, dbig_q[j-1]}) : t[WW-1:0];
        nq_d[j][k]  = {nq_q[j-1][k][DB-2:0], ge};
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NW; k++) begin
      if (dsc_q[DB]) begin
        res_d[k] = dneg_q[DB][k] ? (16'h0 - 16'(nq_q[DB][k])) : 16'(nq_q[DB][k]);
      end else begin
        res_d[k] = du_q[DB][k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q        <= '0;
      out_valid_q <= 1'b0;
    end else if (ben) begin
      vb_q        <= {vb_q[NV-2:0], q_stat_i.nempty};
      out_valid_q <= vb_q[NV-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ben) begin
      for (int k = 0; k < NW; k++) begin
        lo1_q[k] <= in_mag[k][HALF-1:0] * max_speed_i;
        hi1_q[k] <= in_mag[k][WW-1:HALF] * max_speed_i;
        u1_q[k]  <= u_d[k];
      end
      neg1_q <= in_neg;
      big1_q <= in_big;
      sc1_q  <= in_scale;
      for (int k = 0; k < NW; k++) begin
        rem_q[0][k] <= rem_d[0][k];
        nq_q[0][k]  <= nq_d[0][k];
        du_q[0][k]  <= u1_q[k];
      end
      dneg_q[0] <= neg1_q;
      dbig_q[0] <= big1_q;
      dsc_q[0]  <= sc1_q;
      for (int j = 1; j <= DB; j++) begin
        for (int k = 0; k < NW; k++) begin
          rem_q[j][k] <= rem_d[j][k];
          nq_q[j][k]  <= nq_d[j][k];
          du_q[j][k]  <= du_q[j-1][k];
        end
        dneg_q[j] <= dneg_q[j-1];
        dbig_q[j] <= dbig_q[j-1];
        dsc_q[j]  <= dsc_q[j-1];
      end
      for (int k = 0; k < NW; k++) begin
        wheel_q[k] <= res_d[k];
      end
      scaled_q <= dsc_q[DB];
    end
  end

  assign out_valid_o         = out_valid_q;
  assign wheel_front_left_o  = wheel_q[0];
  assign wheel_front_right_o = wheel_q[1];
  assign wheel_rear_right_o  = wheel_q[2];
  assign wheel_rear_left_o   = wheel_q[3];
  assign was_scaled_o        = scaled_q;

endmodule

### sv/mecanum_wheel_speed_mixer_unit.sv
// Top level of the field-oriented mecanum wheel speed mixer
//
//   channel  dir  handshake               payload
//   in       in   in_valid_i/in_stall_o   vel_x_i vel_y_i turn_rate_i heading_i
//   out      out  out_valid_o/out_stall_i wheel_*_o was_scaled_o
//   cfg      in   cfg_we_i                cfg_wdata_i (max_speed)
//
// One request per cycle unless the output stalls; one quotient bit per divider stage.
// With no stall a request passes 10 front stages, the queue and 18 back stages.
// Reset is asynchronous, active low; max_speed resets to 660.
// A stalled output holds the back end; the front keeps going until the 4-entry queue fills.
`timescale 1ns / 1ps
`include "mecanum_wheel_speed_mixer_unit_assert.svh"

module mecanum_wheel_speed_mixer_unit #(
  parameter int unsigned TRIG_FRAC_BITS = mwsm_pkg::TRIG_FRAC_BITS_DEF,
  parameter int unsigned ANGLE_BITS     = mwsm_pkg::ANGLE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [mwsm_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [15:0]         vel_x_i,
  input  logic signed [15:0]         vel_y_i,
  input  logic signed [15:0]         turn_rate_i,
  input  logic [15:0]                heading_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [15:0]         wheel_front_left_o,
  output logic signed [15:0]         wheel_front_right_o,
  output logic signed [15:0]         wheel_rear_right_o,
  output logic signed [15:0]         wheel_rear_left_o,
  output logic                       was_scaled_o
);

  localparam int unsigned EW = mwsm_pkg::entry_w(TRIG_FRAC_BITS);

  logic [mwsm_pkg::CFG_W-1:0] max_speed_q;
  mwsm_pkg::q_stat_t q_stat;
  logic              q_push, q_pop;
  logic [EW-1:0]     q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q <= mwsm_pkg::MAX_SPEED_RST;
    end else if (cfg_we_i) begin
      max_speed_q <= cfg_wdata_i;
    end
  end

  mwsm_front #(
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS),
    .ANGLE_BITS    (ANGLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .vel_x_i     (vel_x_i),
    .vel_y_i     (vel_y_i),
    .turn_rate_i (turn_rate_i),
    .heading_i   (heading_i),
    .max_speed_i (max_speed_q),
    .q_stat_i    (q_stat),
    .q_push_o    (q_push),
    .q_wdata_o   (q_wdata)
  );

  mwsm_queue #(.W(EW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .stat_o  (q_stat)
  );

  mwsm_back #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .q_stat_i            (q_stat),
    .q_rdata_i           (q_rdata),
    .q_pop_o             (q_pop),
    .max_speed_i         (max_speed_q),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .wheel_front_left_o  (wheel_front_left_o),
    .wheel_front_right_o (wheel_front_right_o),
    .wheel_rear_right_o  (wheel_rear_right_o),
    .wheel_rear_left_o   (wheel_rear_left_o),
    .was_scaled_o        (was_scaled_o)
  );

  `MWSM_NEVER(a_q_no_overflow, clk_i, rst_ni, q_push && q_stat.full, "push into full queue")
  `MWSM_NEVER(a_q_no_underflow, clk_i, rst_ni, q_pop && !q_stat.nempty, "pop from empty queue")
  `MWSM_IMPLY(a_stall_only_full, clk_i, rst_ni, in_stall_o, q_stat.full, "front stalled, queue not full")
  `MWSM_NEXT(a_full_holds, clk_i, rst_ni, q_stat.full && !q_pop, q_stat.full, "full queue drained without pop")

endmodule
